[src/assert_macros.svh]
// assertion macros for the checker module
// needs clk and rst_n visible in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off while in reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/gtq_pkg.sv]
// shared types and constants of the team queue engine
// no dependencies
package gtq_pkg;

  localparam int MEMBER_IDS = 1024;
  localparam int GROUPS     = 16;
  localparam int CAPACITY   = 64;
  localparam int NGRP       = GROUPS + 1;

  localparam int MW  = 10;                  // member id bits
  localparam int GW  = 5;                   // group number bits
  localparam int EW  = $clog2(CAPACITY);    // pool entry index bits
  localparam int CW  = $clog2(CAPACITY + 1); // pool count bits
  localparam int MAW = $clog2(MEMBER_IDS);  // group map address bits

  localparam logic [2:0] OP_ASSIGN  = 3'd0;
  localparam logic [2:0] OP_ENQUEUE = 3'd1;
  localparam logic [2:0] OP_DEQUEUE = 3'd2;
  localparam logic [2:0] OP_DUMP    = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  typedef struct packed {
    logic [2:0]    opcode;
    logic [MW-1:0] member;
    logic [GW-1:0] group;
  } in_item_t;

  typedef struct packed {
    logic [MW-1:0] member_out;
    logic [GW-1:0] group_out;
    logic          is_empty;
    logic          overflowed;
    logic          last;
  } out_item_t;

  typedef struct packed {
    logic load;   // take a request into the request register
    logic exec;   // carry out the held request
    logic sweep;  // one step of the map clearing pass
    logic dump;   // list walk in progress
    logic emit;   // load one dump result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       sweep_done;
    logic       out_free;
    logic       dump_last;
  } ctrl_sts_t;

endpackage

[src/gtq_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module gtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/gtq_ctrl.sv]
// controller state machine of the team queue engine
// depends on gtq_pkg
module gtq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gtq_pkg::ctrl_sts_t sts,
  output gtq_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_DRD  = 3'd3;
  localparam logic [2:0] ST_DOUT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.op == gtq_pkg::OP_DUMP) begin
          state_nxt = ST_DRD;
        end else if (sts.op == gtq_pkg::OP_CLEAR) begin
          state_nxt = ST_CLR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRD: begin
        // list memories settle on the current entry
        cmd.dump  = 1'b1;
        state_nxt = ST_DOUT;
      end
      ST_DOUT: begin
        cmd.dump = 1'b1;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.dump_last ? ST_IDLE : ST_DRD;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

[src/gtq_dp.sv]
// datapath: group map, linked pool, group lists, order ring, output register
// depends on gtq_pkg and gtq_ram
module gtq_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  gtq_pkg::in_item_t   in_data,
  input  gtq_pkg::ctrl_cmd_t  cmd,
  output gtq_pkg::ctrl_sts_t  sts,
  output logic                out_valid,
  input  logic                out_stall,
  output gtq_pkg::out_item_t  out_data
);

  localparam int MW   = gtq_pkg::MW;
  localparam int GW   = gtq_pkg::GW;
  localparam int EW   = gtq_pkg::EW;
  localparam int CW   = gtq_pkg::CW;
  localparam int MAW  = gtq_pkg::MAW;
  localparam int NGRP = gtq_pkg::NGRP;
  localparam int CAP  = gtq_pkg::CAPACITY;

  localparam logic [GW-1:0]  LAST_POS  = GW'(NGRP - 1);
  localparam logic [GW:0]    NGRP_W    = (GW + 1)'(NGRP);
  localparam logic [GW-1:0]  MAX_GROUP = GW'(gtq_pkg::GROUPS);
  localparam logic [CW-1:0]  CAP_C     = CW'(CAP);
  localparam logic [MAW-1:0] SWEEP_END = MAW'(gtq_pkg::MEMBER_IDS - 1);

  // control state
  logic                  overflow_r;
  logic [CW-1:0]         free_count_r;
  logic [CAP-1:0]        free_vld_r;
  logic [GW-1:0]         order_front_r;
  logic [GW-1:0]         order_len_r;
  logic [NGRP-1:0]       in_line_r;
  logic [CW-1:0]         size_r [NGRP];
  logic [MAW-1:0]        sweep_cnt_r;
  logic                  out_valid_r;

  // payload state
  gtq_pkg::in_item_t     req_r;
  logic [EW-1:0]         head_r [NGRP];
  logic [EW-1:0]         tail_r [NGRP];
  logic [GW-1:0]         ring_r [NGRP];
  logic [EW-1:0]         walk_e_r;
  logic [CW-1:0]         dleft_r;
  logic [CW-1:0]         dn_r;
  logic [GW-1:0]         dpos_r;
  logic [GW-1:0]         gcur_r;
  logic                  dempty_r;
  logic [EW-1:0]         free_raddr_r;
  logic                  free_rvld_r;
  gtq_pkg::out_item_t    out_data_r;

  // memory ports
  logic [GW-1:0]         map_rdata;
  logic                  map_we;
  logic [MAW-1:0]        map_waddr;
  logic [GW-1:0]         map_wdata;
  logic [MW-1:0]         mem_rdata;
  logic [EW-1:0]         next_rdata;
  logic                  next_we;
  logic [EW-1:0]         next_raddr;
  logic [EW-1:0]         free_rdata;
  logic [EW-1:0]         free_raddr;
  logic                  free_we;

  // decode and selection
  logic                  is_enq;
  logic                  is_deq;
  logic                  is_dump;
  logic                  enq_ok;
  logic                  enq_fail;
  logic [GW-1:0]         front_inc;
  logic [GW-1:0]         dpos_inc;
  logic [GW:0]           pos_sum;
  logic [GW-1:0]         tail_pos;
  logic [GW-1:0]         ring_idx;
  logic [GW-1:0]         ring_g;
  logic [GW-1:0]         gsel;
  logic [EW-1:0]         g_head;
  logic [EW-1:0]         g_tail;
  logic [CW-1:0]         g_size;
  logic                  g_inl;
  logic                  join_line;
  logic [CW-1:0]         eff_size;
  logic [EW-1:0]         fe;
  logic [CW-1:0]         total;
  logic                  dump_last;

  assign is_enq   = cmd.exec && (req_r.opcode == gtq_pkg::OP_ENQUEUE);
  assign is_deq   = cmd.exec && (req_r.opcode == gtq_pkg::OP_DEQUEUE) && (order_len_r != '0);
  assign is_dump  = cmd.exec && (req_r.opcode == gtq_pkg::OP_DUMP);
  assign enq_ok   = is_enq && (free_count_r != '0);
  assign enq_fail = is_enq && (free_count_r == '0);

  assign front_inc = (order_front_r == LAST_POS) ? '0 : order_front_r + 1'b1;
  assign dpos_inc  = (dpos_r == LAST_POS) ? '0 : dpos_r + 1'b1;

  // back of the ring, wrapped once
  assign pos_sum  = {1'b0, order_front_r} + {1'b0, order_len_r};
  assign tail_pos = (pos_sum >= NGRP_W) ? GW'(pos_sum - NGRP_W) : pos_sum[GW-1:0];

  assign ring_idx = cmd.dump ? dpos_inc : order_front_r;
  assign ring_g   = ring_r[ring_idx];
  assign gsel     = is_enq ? map_rdata : ring_g;
  assign g_head   = head_r[gsel];
  assign g_tail   = tail_r[gsel];
  assign g_size   = size_r[gsel];
  assign g_inl    = in_line_r[gsel];

  assign join_line = !g_inl;
  assign eff_size  = join_line ? '0 : g_size;

  // a stack slot never pushed holds its own index
  assign fe = free_rvld_r ? free_rdata : free_raddr_r;

  assign free_raddr = free_count_r[EW-1:0] - 1'b1;
  assign free_we    = is_deq;

  assign map_we    = cmd.sweep ||
                     (cmd.exec && (req_r.opcode == gtq_pkg::OP_ASSIGN) &&
                      (req_r.group <= MAX_GROUP));
  assign map_waddr = cmd.sweep ? sweep_cnt_r : req_r.member;
  assign map_wdata = cmd.sweep ? '0 : req_r.group;

  assign next_we    = enq_ok && (eff_size != '0);
  assign next_raddr = cmd.dump ? walk_e_r : g_head;

  assign total     = CAP_C - free_count_r;
  assign dump_last = dempty_r || (dn_r == total - 1'b1);

  gtq_ram #(.WIDTH(GW), .DEPTH(gtq_pkg::MEMBER_IDS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (in_data.member),
    .rdata (map_rdata)
  );

  gtq_ram #(.WIDTH(MW), .DEPTH(CAP)) u_member_ram (
    .clk   (clk),
    .we    (enq_ok),
    .waddr (fe),
    .wdata (req_r.member),
    .raddr (walk_e_r),
    .rdata (mem_rdata)
  );

  gtq_ram #(.WIDTH(EW), .DEPTH(CAP)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (g_tail),
    .wdata (fe),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

  gtq_ram #(.WIDTH(EW), .DEPTH(CAP)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_count_r[EW-1:0]),
    .wdata (g_head),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overflow_r    <= 1'b0;
      free_count_r  <= CAP_C;
      free_vld_r    <= '0;
      order_front_r <= '0;
      order_len_r   <= '0;
      in_line_r     <= '0;
      for (int i = 0; i < NGRP; i++) begin
        size_r[i] <= '0;
      end
      sweep_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt_r   <= (sweep_cnt_r == SWEEP_END) ? '0 : sweep_cnt_r + 1'b1;
        overflow_r    <= 1'b0;
        free_count_r  <= CAP_C;
        free_vld_r    <= '0;
        order_front_r <= '0;
        order_len_r   <= '0;
        in_line_r     <= '0;
        for (int i = 0; i < NGRP; i++) begin
          size_r[i] <= '0;
        end
      end
      if (enq_fail) begin
        overflow_r <= 1'b1;
      end
      if (enq_ok) begin
        free_count_r <= free_count_r - 1'b1;
        size_r[gsel] <= eff_size + 1'b1;
        if (join_line) begin
          in_line_r[gsel] <= 1'b1;
          order_len_r     <= order_len_r + 1'b1;
        end
      end
      if (is_deq) begin
        free_count_r                     <= free_count_r + 1'b1;
        free_vld_r[free_count_r[EW-1:0]] <= 1'b1;
        size_r[gsel]                     <= g_size - 1'b1;
        // group retires with its last member
        if (g_size == CW'(1)) begin
          in_line_r[gsel] <= 1'b0;
          order_front_r   <= front_inc;
          order_len_r     <= order_len_r - 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    free_raddr_r <= free_raddr;
    free_rvld_r  <= free_vld_r[free_raddr];
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (enq_ok) begin
      if (join_line) begin
        ring_r[tail_pos] <= gsel;
      end
      if (eff_size == '0) begin
        head_r[gsel] <= fe;
      end
      tail_r[gsel] <= fe;
    end
    if (is_deq) begin
      head_r[gsel] <= next_rdata;
    end
    if (is_dump) begin
      dempty_r <= (order_len_r == '0);
      dn_r     <= '0;
      dpos_r   <= order_front_r;
      gcur_r   <= gsel;
      walk_e_r <= g_head;
      dleft_r  <= g_size;
    end
    if (cmd.emit && !dempty_r) begin
      dn_r <= dn_r + 1'b1;
      if (dleft_r == CW'(1)) begin
        dpos_r   <= dpos_inc;
        gcur_r   <= gsel;
        walk_e_r <= g_head;
        dleft_r  <= g_size;
      end else begin
        walk_e_r <= next_rdata;
        dleft_r  <= dleft_r - 1'b1;
      end
    end
    if (cmd.emit) begin
      out_data_r.member_out <= dempty_r ? '0 : mem_rdata;
      out_data_r.group_out  <= dempty_r ? '0 : gcur_r;
      out_data_r.is_empty   <= dempty_r;
      out_data_r.overflowed <= overflow_r;
      out_data_r.last       <= dump_last;
    end
  end

  assign sts.op         = req_r.opcode;
  assign sts.sweep_done = (sweep_cnt_r == SWEEP_END);
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.dump_last  = dump_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/grouped_team_queue.sv]
// team queue engine: assign, enqueue and dequeue requests are taken one at a time
// (accept, then execute against the map and pool memories); unused codes too.
// dump: accept, execute, then per member a read state (the linked list memories have a
// registered read) and an output state, held on stalls; an empty dump gives one result.
// reset and clear run a clearing pass over the whole group map, requests held off.
module grouped_team_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gtq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gtq_pkg::out_item_t out_data
);

  gtq_pkg::ctrl_cmd_t cmd;
  gtq_pkg::ctrl_sts_t sts;

  gtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gtq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[src/gtq_chk.sv]
// port-level checker for the team queue engine, bound to the top level
// depends on gtq_pkg and assert_macros.svh
`include "assert_macros.svh"

module gtq_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input gtq_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input gtq_pkg::out_item_t out_data
);

  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `CHK_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `CHK_SAME(a_empty_marker, out_valid && out_data.is_empty, out_data.last && (out_data.member_out == '0) && (out_data.group_out == '0))
  `CHK_NEXT(a_one_request, in_valid && !in_stall, in_stall)
  `CHK_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

endmodule

bind grouped_team_queue gtq_chk u_gtq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[dv/grouped_team_queue_tb.sv]
// testbench for the team queue engine: directed and random requests, with a predictor
// and an in-order checker of dump results; depends on gtq_pkg and grouped_team_queue
module grouped_team_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int MW          = gtq_pkg::MW;
  localparam int GW          = gtq_pkg::GW;
  localparam int EW          = gtq_pkg::EW;
  localparam int NGRP        = gtq_pkg::NGRP;
  localparam int CAPACITY    = gtq_pkg::CAPACITY;
  localparam int MEMBER_IDS  = gtq_pkg::MEMBER_IDS;
  localparam int GROUPS      = gtq_pkg::GROUPS;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  gtq_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  gtq_pkg::out_item_t out_data;

  grouped_team_queue DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // predictor state
  logic [GW-1:0] map_grp [MEMBER_IDS];
  logic [MW-1:0] ent_mem [CAPACITY];
  logic [EW-1:0] ent_nxt [CAPACITY];
  logic [EW-1:0] free_stk [CAPACITY];
  int            free_n;
  logic [EW-1:0] grp_head [NGRP];
  logic [EW-1:0] grp_tail [NGRP];
  int            grp_size [NGRP];
  bit            grp_line [NGRP];
  int            ring [NGRP];
  int            ring_front, ring_len;
  bit            ovf;

  gtq_pkg::out_item_t expected_dump[$];
  gtq_pkg::in_item_t  pending_reqs[$];
  int        errors, dumps_seen, results_seen, accepted;
  bit        no_idle, hold_in;

  function automatic void add_req(gtq_pkg::in_item_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void add_exp(gtq_pkg::out_item_t o);
    expected_dump = {expected_dump, o};
  endfunction

  function automatic void empty_lists();
    for (int i = 0; i < CAPACITY; i++) begin
      free_stk[i] = EW'(i);
      ent_mem[i] = '0;
      ent_nxt[i] = '0;
    end
    free_n = CAPACITY;
    for (int g = 0; g < NGRP; g++) begin
      grp_size[g] = 0;
      grp_line[g] = 0;
      grp_head[g] = '0;
      grp_tail[g] = '0;
      ring[g] = 0;
    end
    ring_front = 0;
    ring_len = 0;
    ovf = 0;
  endfunction

  function automatic void wipe_all();
    for (int m = 0; m < MEMBER_IDS; m++) map_grp[m] = '0;
    empty_lists();
  endfunction

  function automatic void apply_request(gtq_pkg::in_item_t r);
    int g, e, n, k;
    gtq_pkg::out_item_t o;
    case (r.opcode)
      gtq_pkg::OP_ASSIGN: begin
        if (r.group <= GROUPS) map_grp[r.member] = r.group;
      end
      gtq_pkg::OP_ENQUEUE: begin
        g = int'(map_grp[r.member]);
        if (free_n == 0) begin
          ovf = 1;
        end else begin
          free_n--;
          e = int'(free_stk[free_n]);
          ent_mem[e] = r.member;
          if (!grp_line[g] && ring_len < NGRP) begin
            ring[(ring_front + ring_len) % NGRP] = g;
            ring_len++;
            grp_line[g] = 1;
            grp_size[g] = 0;
          end
          if (grp_size[g] == 0) grp_head[g] = EW'(e);
          else ent_nxt[grp_tail[g]] = EW'(e);
          grp_tail[g] = EW'(e);
          grp_size[g]++;
        end
      end
      gtq_pkg::OP_DEQUEUE: begin
        if (ring_len != 0) begin
          g = ring[ring_front];
          if (grp_size[g] > 0) begin
            e = int'(grp_head[g]);
            grp_head[g] = ent_nxt[e];
            if (free_n < CAPACITY) begin
              free_stk[free_n] = EW'(e);
              free_n++;
            end
            grp_size[g]--;
          end
          if (grp_size[g] == 0) begin
            grp_line[g] = 0;
            ring_front = (ring_front + 1) % NGRP;
            ring_len--;
          end
        end
      end
      gtq_pkg::OP_DUMP: begin
        n = 0;
        for (int i = 0; i < ring_len; i++) begin
          g = ring[(ring_front + i) % NGRP];
          e = int'(grp_head[g]);
          for (int j = 0; j < grp_size[g] && n < CAPACITY; j++) begin
            o = '0;
            o.member_out = ent_mem[e];
            o.group_out = GW'(g);
            o.overflowed = ovf;
            add_exp(o);
            n++;
            e = int'(ent_nxt[e]);
          end
        end
        if (n == 0) begin
          o = '0;
          o.is_empty = 1'b1;
          o.overflowed = ovf;
          add_exp(o);
        end
        k = expected_dump.size() - 1;
        o = expected_dump[k];
        o.last = 1'b1;
        expected_dump[k] = o;
      end
      gtq_pkg::OP_CLEAR: wipe_all();
      default: ;
    endcase
  endfunction

  function automatic gtq_pkg::in_item_t mk(logic [2:0] op, int m, int g);
    gtq_pkg::in_item_t r;
    r.opcode = op;
    r.member = MW'(m);
    r.group = GW'(g);
    return r;
  endfunction

  // driver: requests go out in order, idling at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        apply_request(in_data);
        accepted++;
      end
      if (pending_reqs.size() != 0 && !hold_in && (no_idle || $urandom_range(99) >= 15)) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check each dump result against the oldest prediction
  always @(posedge clk) begin
    gtq_pkg::out_item_t x;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_dump.size() == 0) begin
          $error("unexpected result member_out=%0d", out_data.member_out);
          errors++;
        end else begin
          x = expected_dump.pop_front();
          if (x.last) dumps_seen++;
          if (out_data.member_out !== x.member_out) begin
            $error("member_out exp %0d got %0d", x.member_out, out_data.member_out);
            errors++;
          end
          if (out_data.group_out !== x.group_out) begin
            $error("group_out exp %0d got %0d", x.group_out, out_data.group_out);
            errors++;
          end
          if (out_data.is_empty !== x.is_empty) begin
            $error("is_empty exp %0d got %0d", x.is_empty, out_data.is_empty);
            errors++;
          end
          if (out_data.overflowed !== x.overflowed) begin
            $error("overflowed exp %0d got %0d", x.overflowed, out_data.overflowed);
            errors++;
          end
          if (out_data.last !== x.last) begin
            $error("last exp %0d got %0d", x.last, out_data.last);
            errors++;
          end
        end
      end
      out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 15);
    end
  end

  // watchdog on handshake activity
  int quiet;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_dump.size() != 0)
      @(posedge clk);
  endtask

  // a well-formed burst: for a few members, mostly assign, enqueue it or a random member; dump, dequeue some
  task automatic add_burst();
    int k, m, g;
    k = $urandom_range(1, 8);
    for (int i = 0; i < k; i++) begin
      m = $urandom_range(1023);
      g = $urandom_range(GROUPS);
      if ($urandom_range(3) != 0) add_req(mk(gtq_pkg::OP_ASSIGN, m, g));
      add_req(mk(gtq_pkg::OP_ENQUEUE, ($urandom_range(1) ? m : $urandom_range(1023)), 0));
    end
    add_req(mk(gtq_pkg::OP_DUMP, $urandom_range(1023), $urandom_range(31)));
    k = $urandom_range(0, 5);
    for (int i = 0; i < k; i++)
      add_req(mk(gtq_pkg::OP_DEQUEUE, $urandom_range(1023), $urandom_range(31)));
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    errors = 0; dumps_seen = 0; results_seen = 0; accepted = 0;
    no_idle = 0; hold_in = 0;
    wipe_all();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, extremes, out-of-range assign, unused codes
    add_req(mk(gtq_pkg::OP_DUMP, 0, 0));
    add_req(mk(gtq_pkg::OP_DEQUEUE, 0, 0));
    add_req(mk(gtq_pkg::OP_ASSIGN, 1023, 16));
    add_req(mk(gtq_pkg::OP_ASSIGN, 0, 31));
    add_req(mk(gtq_pkg::OP_ASSIGN, 5, 17));
    add_req(mk(gtq_pkg::OP_ENQUEUE, 1023, 0));
    add_req(mk(gtq_pkg::OP_ENQUEUE, 0, 31));
    add_req(mk(gtq_pkg::OP_ENQUEUE, 1023, 0));
    add_req(mk(gtq_pkg::OP_ENQUEUE, 5, 0));
    add_req(mk(3'd5, 1023, 31));
    add_req(mk(3'd6, 0, 0));
    add_req(mk(3'd7, 512, 16));
    add_req(mk(gtq_pkg::OP_DUMP, 0, 0));
    add_req(mk(gtq_pkg::OP_DEQUEUE, 0, 0));
    add_req(mk(gtq_pkg::OP_DEQUEUE, 0, 0));
    add_req(mk(gtq_pkg::OP_DUMP, 0, 0));
    add_req(mk(gtq_pkg::OP_CLEAR, 1023, 31));
    add_req(mk(gtq_pkg::OP_DUMP, 0, 0));
    wait_drained();

    // fill the pool past capacity, dump the full pool, dequeue one, dump again
    for (int i = 0; i < CAPACITY + 3; i++)
      add_req(mk(gtq_pkg::OP_ENQUEUE, i * 15 % 1024, 0));
    add_req(mk(gtq_pkg::OP_DUMP, 0, 0));
    add_req(mk(gtq_pkg::OP_DEQUEUE, 0, 0));
    add_req(mk(gtq_pkg::OP_DUMP, 0, 0));
    hold_in = 0;
    wait_drained();

    // random: mostly well-formed bursts, some noise and clears
    n = 0;
    while (n < 170) begin
      if (n > 80 && n < 140) no_idle = 1;
      else no_idle = 0;
      if ($urandom_range(9) < 7) begin
        add_burst();
      end else begin
        add_req(mk(3'($urandom_range(7)), $urandom_range(1023), $urandom_range(31)));
        if ($urandom_range(7) == 0) add_req(mk(gtq_pkg::OP_CLEAR, 0, 0));
      end
      n += pending_reqs.size();
      wait_drained();
    end
    add_req(mk(gtq_pkg::OP_DUMP, 0, 0));
    wait_drained();
    repeat (20) @(posedge clk);

    $display("covered %0d requests and %0d dump results over %0d dumps",
             accepted, results_seen, dumps_seen);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
